[sv/ptb_pkg.sv]
`default_nettype none
package ptb_pkg;

  localparam int TS_W         = 64;
  localparam int MASK_W       = 4;
  localparam int NUM_CHANNELS = 4;
  localparam int CH_FIELD_W   = 2;
  localparam int OUT_CNT_W    = 32;
  localparam int S_TDATA_W    = 72;
  localparam int M_TDATA_W    = 168;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_W    = 1;

  // Input tdata layout
  localparam int IN_TS_LSB   = 0;
  localparam int IN_MASK_LSB = IN_TS_LSB + TS_W;
  localparam int IN_LOST_LSB = IN_MASK_LSB + MASK_W;

  // Output tdata layout
  localparam int OUT_CH_LSB     = 0;
  localparam int OUT_START_LSB  = OUT_CH_LSB + CH_FIELD_W;
  localparam int OUT_PHOTON_LSB = OUT_START_LSB + TS_W;
  localparam int OUT_LOST_LSB   = OUT_PHOTON_LSB + OUT_CNT_W;
  localparam int OUT_EMPTY_LSB  = OUT_LOST_LSB + OUT_CNT_W;
  localparam int OUT_USED_W     = OUT_EMPTY_LSB + OUT_CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_WIDTH  = 1'b0,
    CFG_EMIT_EMPTY = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [TS_W-1:0]   timestamp;
    logic [MASK_W-1:0] hit_mask;   // channel mask, already gated by the strobe type
    logic              lost;
  } cmd_t;

endpackage
`default_nettype wire

[sv/ptb_fifo.sv]
`default_nettype none
module ptb_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ptb_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output ptb_pkg::cmd_t      pop_data_o
);
  import ptb_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o     = (fill_q == CntFull);
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[sv/ptb_front.sv]
`default_nettype none
module ptb_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // timestamp[63:0], channel_mask[67:64], lost_flag[68], zero pad
  input  wire logic [ptb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // is_strobe[0]
  input  wire logic                           s_axis_tuser,
  output logic                                cmd_valid_o,
  input  wire logic                           cmd_ready_i,
  output ptb_pkg::cmd_t                       cmd_o
);
  import ptb_pkg::*;

  cmd_t decoded;
  logic full, empty;

  // Delta records carry no strobes: drop their channel bits here.
  always_comb begin
    decoded.timestamp = s_axis_tdata[IN_TS_LSB +: TS_W];
    decoded.hit_mask  = s_axis_tuser ? s_axis_tdata[IN_MASK_LSB +: MASK_W] : '0;
    decoded.lost      = s_axis_tdata[IN_LOST_LSB];
  end

  assign s_axis_tready = !full;
  assign cmd_valid_o   = !empty;

  ptb_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (decoded),
    .full_o      (full),
    .pop_i       (cmd_ready_i),
    .empty_o     (empty),
    .pop_data_o  (cmd_o)
  );

endmodule
`default_nettype wire

[sv/ptb_div.sv]
`default_nettype none
module ptb_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ptb_pkg::TS_W-1:0]  divisor_i,
  input  wire logic [ptb_pkg::TS_W-1:0]  dvd_a_i,
  input  wire logic [ptb_pkg::TS_W-1:0]  dvd_b_i,
  output logic                           done_o,
  output logic [ptb_pkg::TS_W-1:0]       quo_a_o,
  output logic [ptb_pkg::TS_W-1:0]       rem_a_o,
  output logic [ptb_pkg::TS_W-1:0]       quo_b_o
);
  import ptb_pkg::*;

  localparam int StepW = $clog2(TS_W);

  logic             busy_q, busy_d, done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [TS_W-1:0]  dsr_q, dsr_d;
  logic [TS_W-1:0]  rem_a_q, rem_a_d, qa_q, qa_d;
  logic [TS_W-1:0]  rem_b_q, rem_b_d, qb_q, qb_d;
  logic [TS_W:0]    trial_a, trial_b, diff_a, diff_b;
  logic             ge_a, ge_b;

  // One restoring step per cycle on both lanes, shared divisor.
  always_comb begin
    trial_a = {rem_a_q, qa_q[TS_W-1]};
    trial_b = {rem_b_q, qb_q[TS_W-1]};
    diff_a  = trial_a - {1'b0, dsr_q};
    diff_b  = trial_b - {1'b0, dsr_q};
    ge_a    = (trial_a >= {1'b0, dsr_q});
    ge_b    = (trial_b >= {1'b0, dsr_q});
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    dsr_d   = dsr_q;
    rem_a_d = rem_a_q;
    qa_d    = qa_q;
    rem_b_d = rem_b_q;
    qb_d    = qb_q;
    if (start_i) begin
      busy_d  = 1'b1;
      step_d  = '0;
      dsr_d   = divisor_i;
      rem_a_d = '0;
      qa_d    = dvd_a_i;
      rem_b_d = '0;
      qb_d    = dvd_b_i;
    end else if (busy_q) begin
      step_d  = step_q + 1'b1;
      rem_a_d = ge_a ? diff_a[TS_W-1:0] : trial_a[TS_W-1:0];
      qa_d    = {qa_q[TS_W-2:0], ge_a};
      rem_b_d = ge_b ? diff_b[TS_W-1:0] : trial_b[TS_W-1:0];
      qb_d    = {qb_q[TS_W-2:0], ge_b};
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q   <= dsr_d;
    rem_a_q <= rem_a_d;
    qa_q    <= qa_d;
    rem_b_q <= rem_b_d;
    qb_q    <= qb_d;
  end

  assign done_o  = done_q;
  assign quo_a_o = qa_q;
  assign rem_a_o = rem_a_q;
  assign quo_b_o = qb_q;

endmodule
`default_nettype wire

[sv/ptb_back.sv]
`default_nettype none
module ptb_back #(
  parameter int COUNT_BITS   = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cmd_valid_i,
  output logic                                cmd_ready_o,
  input  wire ptb_pkg::cmd_t                  cmd_i,
  input  wire logic [ptb_pkg::TS_W-1:0]       bin_width_i,
  input  wire logic                           emit_empty_i,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [ptb_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast
);
  import ptb_pkg::*;

  localparam int ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PadW = M_TDATA_W - OUT_USED_W;
  localparam logic [ChW-1:0]        ChLast = ChW'(NUM_CHANNELS - 1);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  back_state_e state_q, state_d;

  logic                  started_q, started_d;
  logic [TS_W-1:0]       start_q, start_d;
  logic [COUNT_BITS-1:0] cnt_q [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] cnt_d [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] lost_q, lost_d;
  logic [ChW-1:0]        chi_q, chi_d;

  cmd_t                  item_q, item_d;
  logic                  first_q, first_d;
  logic [TS_W-1:0]       new_start_q, new_start_d;
  logic [OUT_CNT_W-1:0]  empties_q, empties_d;

  logic                  out_valid_q, out_valid_d;
  logic [CH_FIELD_W-1:0] out_ch_q, out_ch_d;
  logic [TS_W-1:0]       out_start_q, out_start_d;
  logic [OUT_CNT_W-1:0]  out_photon_q, out_photon_d;
  logic [OUT_CNT_W-1:0]  out_lost_q, out_lost_d;
  logic [OUT_CNT_W-1:0]  out_empty_q, out_empty_d;
  logic                  out_last_q, out_last_d;

  logic [TS_W-1:0]         eff_len, quo_a, rem_a, quo_b, gap;
  logic                    pop, is_close, div_start, div_done;
  logic [NUM_CHANNELS-1:0] sel, hit_vec;
  logic                    later, out_free, step, finishing, apply;
  cmd_t                    cnt_item;

  assign eff_len     = (bin_width_i == '0) ? TS_W'(1) : bin_width_i;
  assign cmd_ready_o = (state_q == BK_IDLE);
  assign pop         = (state_q == BK_IDLE) && cmd_valid_i;
  assign is_close    = started_q && (cmd_i.timestamp >= start_q)
                       && ((cmd_i.timestamp - start_q) >= eff_len);
  assign div_start   = pop && (!started_q || is_close);

  ptb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (eff_len),
    .dvd_a_i   (cmd_i.timestamp),
    .dvd_b_i   (start_q),
    .done_o    (div_done),
    .quo_a_o   (quo_a),
    .rem_a_o   (rem_a),
    .quo_b_o   (quo_b)
  );

  // Empty bins strictly between old and new start: floor(t/len) - floor(start/len) - 1
  assign gap = quo_a - quo_b - TS_W'(1);

  always_comb begin
    later = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sel[i] = emit_empty_i || (cnt_q[i] != '0);
      if (i > int'(chi_q) && sel[i]) begin
        later = 1'b1;
      end
    end
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  assign step      = (state_q == BK_EMIT) && (!sel[chi_q] || out_free);
  assign finishing = step && (chi_q == ChLast);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (div_start) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_d = first_q ? BK_IDLE : BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (finishing) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Counter update: the closing record is counted into the fresh bin.
  always_comb begin
    cnt_item = cmd_i;
    apply    = pop && started_q && !is_close;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    lost_d = lost_q;
    if (finishing) begin
      cnt_item = item_q;
      apply    = 1'b1;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_d[i] = '0;
      end
      lost_d = '0;
    end
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      hit_vec[i] = (i < MASK_W) ? cnt_item.hit_mask[i % MASK_W] : 1'b0;
    end
    if (apply) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (hit_vec[i] && cnt_d[i] != CntMax) begin
          cnt_d[i] = cnt_d[i] + 1'b1;
        end
      end
      if (cnt_item.lost && lost_d != CntMax) begin
        lost_d = lost_d + 1'b1;
      end
    end
  end

  // Datapath and output register
  always_comb begin
    started_d    = started_q;
    start_d      = start_q;
    chi_d        = chi_q;
    item_d       = item_q;
    first_d      = first_q;
    new_start_d  = new_start_q;
    empties_d    = empties_q;
    out_valid_d  = out_valid_q;
    out_ch_d     = out_ch_q;
    out_start_d  = out_start_q;
    out_photon_d = out_photon_q;
    out_lost_d   = out_lost_q;
    out_empty_d  = out_empty_q;
    out_last_d   = out_last_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      item_d  = cmd_i;
      first_d = !started_q;
    end

    if (state_q == BK_DIV && div_done) begin
      if (first_q) begin
        started_d = 1'b1;
        start_d   = item_q.timestamp - rem_a;
      end else begin
        new_start_d = item_q.timestamp - rem_a;
        chi_d       = '0;
        if (!emit_empty_i) begin
          empties_d = '0;
        end else if (gap[TS_W-1:OUT_CNT_W] != '0) begin
          empties_d = '1;
        end else begin
          empties_d = gap[OUT_CNT_W-1:0];
        end
      end
    end

    if (step) begin
      chi_d = chi_q + 1'b1;
      if (sel[chi_q]) begin
        out_valid_d  = 1'b1;
        out_ch_d     = CH_FIELD_W'(chi_q);
        out_start_d  = start_q;
        out_photon_d = OUT_CNT_W'(cnt_q[chi_q]);
        out_lost_d   = OUT_CNT_W'(lost_q);
        out_empty_d  = empties_q;
        out_last_d   = !later;
      end
    end

    if (finishing) begin
      start_d = new_start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      started_q   <= 1'b0;
      start_q     <= '0;
      lost_q      <= '0;
      chi_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      start_q     <= start_d;
      lost_q      <= lost_d;
      chi_q       <= chi_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    first_q      <= first_d;
    new_start_q  <= new_start_d;
    empties_q    <= empties_d;
    out_ch_q     <= out_ch_d;
    out_start_q  <= out_start_d;
    out_photon_q <= out_photon_d;
    out_lost_q   <= out_lost_d;
    out_empty_q  <= out_empty_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_empty_q, out_lost_q, out_photon_q,
                          out_start_q, out_ch_q};

endmodule
`default_nettype wire

[sv/photon_time_binner.sv]
// Plain record (no bin closed): queued, then popped and counted once the back end is idle;
// one a cycle while it stays idle. First record after reset: after its pop the divider loads,
// runs 64 divider steps and hands off before the next pop; no results. Bin-closing record:
// the same divider run, then an emit step per channel; m_axis_tready stalls hold the emits.
// The two-entry queue keeps taking requests while the back end works, until it is full.
// rst_ni (asynchronous, active low) clears control state and counters; bin width 1, empty bins emitted.
`default_nettype none
module photon_time_binner #(
  parameter int COUNT_BITS   = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ptb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ptb_pkg::TS_W-1:0]          cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // timestamp[63:0], channel_mask[67:64], lost_flag[68], zero pad
  input  wire logic [ptb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // is_strobe[0]
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // channel[1:0], start_time[65:2], photon_count[97:66], lost_count[129:98],
  // empty_bins_after[161:130], zero pad
  output logic [ptb_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import ptb_pkg::*;

  logic [TS_W-1:0] bin_len_q, bin_len_d;
  logic            emit_empty_q, emit_empty_d;
  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;

  always_comb begin
    bin_len_d    = bin_len_q;
    emit_empty_d = emit_empty_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BIN_WIDTH:  bin_len_d    = cfg_wdata_i;
        CFG_EMIT_EMPTY: emit_empty_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_len_q    <= TS_W'(1);
      emit_empty_q <= 1'b1;
    end else begin
      bin_len_q    <= bin_len_d;
      emit_empty_q <= emit_empty_d;
    end
  end

  ptb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  ptb_back #(
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .bin_width_i   (bin_len_q),
    .emit_empty_i  (emit_empty_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

[sv/ptb_checker.sv]
`default_nettype none
module ptb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [ptb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [ptb_pkg::TS_W-1:0]      cfg_wdata_i,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [ptb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);
  import ptb_pkg::*;

  logic emit_q;

  // Track the empty-bin mode from the write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b1;
    end else if (cfg_we_i && cfg_idx_i == CFG_EMIT_EMPTY) begin
      emit_q <= cfg_wdata_i[0];
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result request changed while stalled");

  a_omit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !emit_q |->
      m_axis_tdata[OUT_PHOTON_LSB +: OUT_CNT_W] != '0
      && m_axis_tdata[OUT_EMPTY_LSB +: OUT_CNT_W] == '0)
    else $error("zero bin or empty run reported while omitting empties");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result request right after reset");

endmodule

bind photon_time_binner ptb_checker u_ptb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import ptb_pkg::*;

  typedef struct packed {
    logic [TS_W-1:0]   ts;
    logic [MASK_W-1:0] mask;
    logic              lost;
    logic              strobe;
  } photon_record_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [TS_W-1:0]       start;
    logic [OUT_CNT_W-1:0]  photons;
    logic [OUT_CNT_W-1:0]  lost;
    logic [OUT_CNT_W-1:0]  empties;
    logic                  last;
  } closed_bin_t;

  localparam int NCH = 4;
  localparam logic [OUT_CNT_W-1:0] CNT_MAX = '1;

  // Per-channel bin counting, mirrored at the block's widths.
  class bin_tally_checker;
    closed_bin_t          pending_bins[$];
    logic [TS_W-1:0]      bin_len;
    logic                 emit_empty;
    logic                 started;
    logic [TS_W-1:0]      cur_start;
    logic [OUT_CNT_W-1:0] photons[NCH];
    logic [OUT_CNT_W-1:0] lost_tally;
    int                   mismatches;

    function new();
      bin_len    = 64'd1;
      emit_empty = 1'b1;
      started    = 1'b0;
      cur_start  = '0;
      lost_tally = '0;
      mismatches = 0;
      foreach (photons[i]) photons[i] = '0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [TS_W-1:0] value);
      if (idx == CFG_BIN_WIDTH) bin_len = value;
      else emit_empty = value[0];
    endfunction

    function void note_record(photon_record_t rec);
      logic [TS_W-1:0] len;
      logic [TS_W-1:0] new_start;
      logic [TS_W-1:0] runs;
      closed_bin_t     res;
      int              last_ch;
      len = (bin_len == '0) ? 64'd1 : bin_len;
      if (!started) begin
        // first record only aligns the bin start
        started   = 1'b1;
        cur_start = rec.ts - (rec.ts % len);
        return;
      end
      if (rec.ts >= cur_start && rec.ts - cur_start >= len) begin
        new_start = rec.ts - (rec.ts % len);
        runs = '0;
        if (emit_empty) begin
          runs = (new_start - cur_start - 64'd1) / len;
          if (runs > 64'hFFFF_FFFF) runs = 64'hFFFF_FFFF;
        end
        last_ch = -1;
        for (int ch = 0; ch < NCH; ch++)
          if (emit_empty || photons[ch] != '0) last_ch = ch;
        for (int ch = 0; ch < NCH; ch++) begin
          if (emit_empty || photons[ch] != '0) begin
            res.channel = ch[CH_FIELD_W-1:0];
            res.start   = cur_start;
            res.photons = photons[ch];
            res.lost    = lost_tally;
            res.empties = runs[OUT_CNT_W-1:0];
            res.last    = (ch == last_ch);
            pending_bins.push_back(res);
          end
          photons[ch] = '0;
        end
        lost_tally = '0;
        cur_start  = new_start;
      end
      if (rec.lost && lost_tally != CNT_MAX) lost_tally++;
      if (rec.strobe)
        for (int ch = 0; ch < NCH; ch++)
          if (rec.mask[ch] && photons[ch] != CNT_MAX) photons[ch]++;
    endfunction

    function void check_bin(logic [M_TDATA_W-1:0] tdata, logic tlast);
      closed_bin_t got;
      closed_bin_t want;
      got.channel = tdata[OUT_CH_LSB +: CH_FIELD_W];
      got.start   = tdata[OUT_START_LSB +: TS_W];
      got.photons = tdata[OUT_PHOTON_LSB +: OUT_CNT_W];
      got.lost    = tdata[OUT_LOST_LSB +: OUT_CNT_W];
      got.empties = tdata[OUT_EMPTY_LSB +: OUT_CNT_W];
      got.last    = tlast;
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bin: ch %0d start %h count %0d lost %0d empties %0d last %0b",
                   got.channel, got.start, got.photons, got.lost, got.empties, got.last);
        return;
      end
      want = pending_bins.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("bin mismatch: got ch %0d start %h count %0d lost %0d empties %0d last %0b",
                   got.channel, got.start, got.photons, got.lost, got.empties, got.last);
          $display("          expected ch %0d start %h count %0d lost %0d empties %0d last %0b",
                   want.channel, want.start, want.photons, want.lost, want.empties,
                   want.last);
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_BIN_WIDTH;
  logic [TS_W-1:0]        cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;

  bin_tally_checker sb;
  logic [TS_W-1:0]  cur_time;
  int               burst_left   = 0;
  bit               tx_gaps      = 1'b0;
  int               rx_mode      = 0;
  bit               hold_request = 1'b0;
  int               hold_left    = 0;
  int               rx_pattern   = 0;

  photon_time_binner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: check at the edge, then pick tready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_bin(m_axis_tdata, m_axis_tlast);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 1000;
    end
    rx_pattern++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
        default: m_axis_tready <= (rx_pattern % 4 == 0);
      endcase
    end
  end

  function automatic photon_record_t make_record(logic [TS_W-1:0] ts, logic [MASK_W-1:0] mask,
                                                 logic lost, logic strobe);
    photon_record_t rec;
    rec.ts     = ts;
    rec.mask   = mask;
    rec.lost   = lost;
    rec.strobe = strobe;
    return rec;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_record(photon_record_t rec);
    s_axis_tvalid <= 1'b1;
    // pad, lost_flag, channel_mask, timestamp
    s_axis_tdata  <= {{(S_TDATA_W - TS_W - MASK_W - 1){1'b0}}, rec.lost, rec.mask, rec.ts};
    s_axis_tuser  <= rec.strobe;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_record(rec);
  endtask

  task automatic pace_sender();
    if (!tx_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
    burst_left = $urandom_range(0, 15);
  endtask

  // Hold until every bin has come out, then give queued closing requests time to finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [TS_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_register(idx, value);
  endtask

  task automatic reconfigure(logic [TS_W-1:0] len, logic emit);
    drain();
    write_register(CFG_BIN_WIDTH, len);
    write_register(CFG_EMIT_EMPTY, {63'd0, emit});
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int count, logic [TS_W-1:0] len, logic emit);
    logic [TS_W-1:0] span;
    logic [TS_W-1:0] step;
    logic [TS_W-1:0] ts;
    int              sel;
    reconfigure(len, emit);
    span = (len == '0) ? 64'd1 : len;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) step = '0;
      else if (sel < 65) step = rand64() % span;
      else if (sel < 88) step = span + rand64() % (span * 3);
      else if (sel < 94) step = rand64() % (span * 40);
      else step = rand64() % 64'h10_0000_0000;
      cur_time += step;
      ts = cur_time;
      // occasional request behind the current time
      if ($urandom_range(0, 19) == 0) ts = cur_time - TS_W'($urandom_range(1, 50));
      send_record(make_record(ts, MASK_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) != 0)));
      pace_sender();
    end
  endtask

  initial begin
    logic [TS_W-1:0] len;
    logic            emit;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_record(make_record(64'd0, 4'hF, 1'b1, 1'b1));
    send_record(make_record(64'd0, 4'hF, 1'b1, 1'b1));
    send_record(make_record(64'd0, 4'hF, 1'b0, 1'b0));
    send_record(make_record(64'd1, 4'h0, 1'b0, 1'b1));
    send_record(make_record(64'd5, 4'h3, 1'b1, 1'b1));
    send_record(make_record(64'd2, 4'hA, 1'b0, 1'b1));
    // zero length acts as one; empty bins omitted
    reconfigure(64'd0, 1'b0);
    send_record(make_record(64'd6, 4'h5, 1'b0, 1'b1));
    send_record(make_record(64'd7, 4'h0, 1'b1, 1'b1));
    send_record(make_record(64'd8, 4'hF, 1'b1, 1'b0));
    send_record(make_record(64'd12, 4'h0, 1'b0, 1'b1));
    // new length against a start aligned to the old one
    reconfigure(64'd7, 1'b1);
    send_record(make_record(64'd40, 4'h6, 1'b0, 1'b1));
    send_record(make_record(64'd41, 4'hF, 1'b1, 1'b1));
    reconfigure('1, 1'b1);
    send_record(make_record(64'd1000, 4'h9, 1'b1, 1'b1));
    // empty run too long for the count field
    reconfigure(64'd1, 1'b1);
    send_record(make_record(64'h1_0000_1000, 4'hF, 1'b0, 1'b1));
    cur_time = 64'h1_0000_1000;

    for (int p = 0; p < 10; p++) begin
      tx_gaps = (p != 0 && p != 6);
      rx_mode = (p == 0 || p == 6) ? 0 : $urandom_range(0, 2);
      case (p)
        0: begin len = TS_W'($urandom_range(1, 8)); emit = 1'b0; end
        1: begin len = 64'd1; emit = 1'b1; end
        2: begin len = 64'd0; emit = 1'b1; end
        default: begin
          case ($urandom_range(0, 3))
            0: len = TS_W'($urandom_range(1, 16));
            1: len = TS_W'($urandom_range(17, 1000));
            2: len = 64'h2_0000_0000 + TS_W'($urandom_range(0, 255));
            default: len = TS_W'($urandom_range(2, 4));
          endcase
          emit = 1'($urandom_range(0, 1));
        end
      endcase
      // jump far ahead so the upper timestamp bits move
      if ((p == 4 || p == 8) && cur_time < 64'h4000_0000_0000_0000)
        cur_time += rand64() >> 3;
      if (p == 3) begin
        drain();
        hold_request = 1'b1;
      end
      run_phase(30, len, emit);
    end

    reconfigure(64'd1, 1'b1);
    send_record(make_record('1, 4'hF, 1'b1, 1'b1));
    drain();

    if (sb.pending_bins.size() != 0)
      $display("%0d expected bins never came out", sb.pending_bins.size());
    if (sb.mismatches == 0 && sb.pending_bins.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
